@@ hdl/smbus_register_pointer_gpio_regs_assert.svh @@
// Assertion macros for the GPIO expander register file checker
`ifndef SMBUS_REGISTER_POINTER_GPIO_REGS_ASSERT_SVH
`define SMBUS_REGISTER_POINTER_GPIO_REGS_ASSERT_SVH

// same-cycle implication, clocked on clk, quiet while rst_n is low
`define SRPG_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srpg check failed");

// next-cycle implication
`define SRPG_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srpg check failed");

`endif

@@ hdl/srpg_pkg.sv @@
// Shared types, register map constants and slot lookup for the expander register file
package srpg_pkg;

  typedef logic [7:0] byte_t;

  typedef enum logic [1:0] {
    MODE_POINTER = 2'd0,
    MODE_WRITE   = 2'd1,
    MODE_READ    = 2'd2,
    MODE_UNUSED  = 2'd3
  } mode_t;

  typedef struct packed {
    mode_t mode;
    byte_t bus_byte;
  } in_item_t;

  typedef struct packed {
    byte_t read_data;
    logic  write_ignored;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } cmd_t;

  // configuration register indexes
  localparam int CFG_IDX_W = 1;
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_P1_STRAP = 1'b0,
    CFG_P2_STRAP = 1'b1
  } cfg_idx_t;

  localparam int NUM_SLOTS = 12;
  localparam int SLOT_W    = $clog2(NUM_SLOTS);

  localparam byte_t SLOT_INDEX [NUM_SLOTS] = '{
    8'h01, 8'h02, 8'h03, 8'h04, 8'h09, 8'h0a, 8'h0b, 8'h0c, 8'h12, 8'h13, 8'h14, 8'h15
  };
  localparam byte_t SLOT_RESET [NUM_SLOTS] = '{
    8'h00, 8'hf0, 8'hff, 8'h00, 8'h00, 8'h70, 8'h7f, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // fixed and strap-backed register addresses
  localparam byte_t REG_P1_INPUT  = 8'h00;
  localparam byte_t REG_P1_LATCH  = 8'h05;
  localparam byte_t REG_P2_INPUT  = 8'h08;
  localparam byte_t REG_P2_LATCH  = 8'h0d;
  localparam byte_t REG_P1_INT_ST = 8'h10;
  localparam byte_t REG_P2_INT_ST = 8'h11;
  localparam byte_t REG_ID_HIGH   = 8'h20;
  localparam byte_t REG_ID_LOW    = 8'h21;

  localparam byte_t ID_HIGH_VALUE  = 8'h60;
  localparam byte_t ID_LOW_VALUE   = 8'h13;
  localparam byte_t INT_ST_VALUE   = 8'h00;
  localparam byte_t RESERVED_VALUE = 8'hff;

  typedef struct packed {
    logic              hit;
    logic [SLOT_W-1:0] slot;
  } slot_hit_t;

  function automatic slot_hit_t slot_lookup(input byte_t idx);
    slot_hit_t r;
    r.hit  = 1'b0;
    r.slot = '0;
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (SLOT_INDEX[k] == idx) begin
        r.hit  = 1'b1;
        r.slot = SLOT_W'(k);
      end
    end
    return r;
  endfunction

endpackage

@@ hdl/smbus_register_pointer_gpio_regs.sv @@
// Top level of the pointer-addressed GPIO expander register file
// Each bus word is taken when start is high and busy low; busy is then high for
// one execute cycle, and the result appears with out_valid for exactly one cycle
// after that. A new word may be started in the same cycle that a result is
// shown, but none is taken while busy, as the controller has a single execute
// state. Results cannot be held off. Pointer words return zeros, data words flag
// write_ignored when the pointer is not on a writable register, and every data
// or read word advances the pointer modulo 256. Strap registers may be written
// only while the block is idle.
module smbus_register_pointer_gpio_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  srpg_pkg::in_item_t             in_item,
  output logic                           out_valid,
  output srpg_pkg::out_item_t            out_item,
  input  logic                           cfg_we,
  input  logic [srpg_pkg::CFG_IDX_W-1:0] cfg_index,
  input  srpg_pkg::byte_t                cfg_data
);

  srpg_pkg::cmd_t cmd;

  srpg_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .cmd       (cmd),
    .out_valid (out_valid)
  );

  srpg_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_item   (in_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .out_item  (out_item)
  );

endmodule

@@ hdl/srpg_ctrl.sv @@
// Controller: sequences capture and execute of one bus word and strobes the result
module srpg_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  output srpg_pkg::cmd_t cmd,
  output logic          out_valid
);

  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_EXEC;
      end
      ST_EXEC: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign busy        = (state_r == ST_EXEC);
  assign cmd.capture = start && (state_r == ST_IDLE);
  assign cmd.execute = (state_r == ST_EXEC);
  assign out_valid   = out_valid_r;

endmodule

@@ hdl/srpg_dp.sv @@
// Datapath: pointer, writable registers, straps and result register
module srpg_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  srpg_pkg::cmd_t                       cmd,
  input  srpg_pkg::in_item_t                   in_item,
  input  logic                                 cfg_we,
  input  logic [srpg_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  srpg_pkg::byte_t                      cfg_data,
  output srpg_pkg::out_item_t                  out_item
);

  srpg_pkg::in_item_t  item_r;
  srpg_pkg::byte_t     ptr_r, ptr_nxt;
  srpg_pkg::byte_t     store_r [srpg_pkg::NUM_SLOTS];
  srpg_pkg::byte_t     p1_strap_r, p2_strap_r;
  srpg_pkg::out_item_t out_r, out_nxt;
  srpg_pkg::slot_hit_t hit;
  srpg_pkg::byte_t     rd_val;
  logic                store_we;

  assign hit = srpg_pkg::slot_lookup(ptr_r);

  always_comb begin
    if (hit.hit) begin
      rd_val = store_r[hit.slot];
    end else begin
      unique case (ptr_r)
        srpg_pkg::REG_P1_INPUT,
        srpg_pkg::REG_P1_LATCH:  rd_val = p1_strap_r;
        srpg_pkg::REG_P2_INPUT,
        srpg_pkg::REG_P2_LATCH:  rd_val = p2_strap_r;
        srpg_pkg::REG_P1_INT_ST,
        srpg_pkg::REG_P2_INT_ST: rd_val = srpg_pkg::INT_ST_VALUE;
        srpg_pkg::REG_ID_HIGH:   rd_val = srpg_pkg::ID_HIGH_VALUE;
        srpg_pkg::REG_ID_LOW:    rd_val = srpg_pkg::ID_LOW_VALUE;
        default:                 rd_val = srpg_pkg::RESERVED_VALUE;
      endcase
    end
  end

  always_comb begin
    ptr_nxt                = ptr_r;
    store_we               = 1'b0;
    out_nxt                = out_r;
    if (cmd.execute) begin
      out_nxt.read_data     = '0;
      out_nxt.write_ignored = 1'b0;
      unique case (item_r.mode)
        srpg_pkg::MODE_POINTER: ptr_nxt = item_r.bus_byte;
        srpg_pkg::MODE_WRITE: begin
          store_we              = hit.hit;
          out_nxt.write_ignored = !hit.hit;
          ptr_nxt               = ptr_r + 8'd1;
        end
        srpg_pkg::MODE_READ: begin
          out_nxt.read_data = rd_val;
          ptr_nxt           = ptr_r + 8'd1;
        end
        srpg_pkg::MODE_UNUSED: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) item_r <= in_item;
    out_r <= out_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ptr_r      <= '0;
      p1_strap_r <= '0;
      p2_strap_r <= '0;
      for (int k = 0; k < srpg_pkg::NUM_SLOTS; k++) begin
        store_r[k] <= srpg_pkg::SLOT_RESET[k];
      end
    end else begin
      ptr_r <= ptr_nxt;
      if (store_we) store_r[hit.slot] <= item_r.bus_byte;
      if (cfg_we) begin
        unique case (srpg_pkg::cfg_idx_t'(cfg_index))
          srpg_pkg::CFG_P1_STRAP: p1_strap_r <= cfg_data;
          srpg_pkg::CFG_P2_STRAP: p2_strap_r <= cfg_data;
        endcase
      end
    end
  end

  assign out_item = out_r;

endmodule

@@ hdl/srpg_checker.sv @@
// Port-level checker for the expander register file, bound to the top level
`include "smbus_register_pointer_gpio_regs_assert.svh"

module srpg_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input srpg_pkg::out_item_t out_item
);

  // every accepted word executes for one cycle, then strobes its result
  `SRPG_ASSERT_NEXT(a_accept_busy, start && !busy, busy)
  `SRPG_ASSERT_NEXT(a_accept_result, start && !busy, ##1 out_valid)
  `SRPG_ASSERT_NEXT(a_busy_one_cycle, busy, !busy && out_valid)
  `SRPG_ASSERT_NOW(a_result_after_busy, out_valid, $past(busy) && !busy)
  // a flagged write never carries read data
  `SRPG_ASSERT_NOW(a_ignored_no_data, out_valid && out_item.write_ignored,
                   out_item.read_data == 8'h00)

endmodule

bind smbus_register_pointer_gpio_regs srpg_checker u_srpg_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

@@ tb/tb.sv @@
// Self-checking testbench for the pointer-addressed GPIO expander register file
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  logic                           clk = 1'b0;
  logic                           rst_n = 1'b0;
  logic                           start = 1'b0;
  logic                           busy;
  srpg_pkg::in_item_t             in_item = '0;
  logic                           out_valid;
  srpg_pkg::out_item_t            out_item;
  logic                           cfg_we = 1'b0;
  logic [srpg_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  srpg_pkg::byte_t                cfg_data = '0;

  smbus_register_pointer_gpio_regs dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #4 clk = ~clk;

  // shadow of the register file
  srpg_pkg::byte_t     shadow_regs [srpg_pkg::NUM_SLOTS];
  srpg_pkg::byte_t     shadow_ptr;
  srpg_pkg::byte_t     strap_p1;
  srpg_pkg::byte_t     strap_p2;
  srpg_pkg::out_item_t pending_q [$];

  int  mismatches;
  int  results_seen;
  int  n_pointer, n_write, n_read, n_unused, n_ignored;
  bit  gaps_on;

  function automatic int slot_of_addr(srpg_pkg::byte_t a);
    for (int k = 0; k < srpg_pkg::NUM_SLOTS; k++)
      if (srpg_pkg::SLOT_INDEX[k] == a) return k;
    return -1;
  endfunction

  function automatic srpg_pkg::byte_t reg_value(srpg_pkg::byte_t a);
    int k;
    k = slot_of_addr(a);
    if (k >= 0) return shadow_regs[k];
    case (a)
      srpg_pkg::REG_P1_INPUT, srpg_pkg::REG_P1_LATCH:   return strap_p1;
      srpg_pkg::REG_P2_INPUT, srpg_pkg::REG_P2_LATCH:   return strap_p2;
      srpg_pkg::REG_P1_INT_ST, srpg_pkg::REG_P2_INT_ST: return srpg_pkg::INT_ST_VALUE;
      srpg_pkg::REG_ID_HIGH:                            return srpg_pkg::ID_HIGH_VALUE;
      srpg_pkg::REG_ID_LOW:                             return srpg_pkg::ID_LOW_VALUE;
      default:                                          return srpg_pkg::RESERVED_VALUE;
    endcase
  endfunction

  // updates the shadow and returns the result word the block should give
  function automatic srpg_pkg::out_item_t apply_word(srpg_pkg::in_item_t w);
    srpg_pkg::out_item_t r;
    int                  k;
    r = '0;
    case (w.mode)
      srpg_pkg::MODE_POINTER: shadow_ptr = w.bus_byte;
      srpg_pkg::MODE_WRITE: begin
        k = slot_of_addr(shadow_ptr);
        if (k >= 0) shadow_regs[k] = w.bus_byte;
        else r.write_ignored = 1'b1;
        shadow_ptr = shadow_ptr + 8'd1;
      end
      srpg_pkg::MODE_READ: begin
        r.read_data = reg_value(shadow_ptr);
        shadow_ptr  = shadow_ptr + 8'd1;
      end
      default: ;
    endcase
    return r;
  endfunction

  task automatic send_word(srpg_pkg::mode_t m, srpg_pkg::byte_t b);
    srpg_pkg::in_item_t  w;
    srpg_pkg::out_item_t r;
    int                  gap;
    w.mode     = m;
    w.bus_byte = b;
    gap = gaps_on ? $urandom_range(0, 7) : 0;
    // start stays high across back-to-back words
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= w;
    @(posedge clk);
    while (busy) @(posedge clk);
    r = apply_word(w);
    pending_q.push_back(r);
    case (m)
      srpg_pkg::MODE_POINTER: n_pointer++;
      srpg_pkg::MODE_WRITE:   n_write++;
      srpg_pkg::MODE_READ:    n_read++;
      default:                n_unused++;
    endcase
    if (r.write_ignored) n_ignored++;
  endtask

  task automatic wait_idle();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_q.size() != 0 && guard < 200) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  task automatic write_strap(srpg_pkg::cfg_idx_t idx, srpg_pkg::byte_t v);
    wait_idle();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == srpg_pkg::CFG_P1_STRAP) strap_p1 = v;
    else strap_p2 = v;
  endtask

  task automatic note_mismatch(string what, int want, int got);
    mismatches++;
    if (mismatches <= 10)
      $display("%0t: %s mismatch: expected %0h, got %0h", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    srpg_pkg::out_item_t want;
    if (rst_n && out_valid) begin
      results_seen++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result word %0h with nothing expected", $realtime, out_item);
      end else begin
        want = pending_q.pop_front();
        if (out_item.read_data !== want.read_data)
          note_mismatch("read_data", int'(want.read_data), int'(out_item.read_data));
        if (out_item.write_ignored !== want.write_ignored)
          note_mismatch("write_ignored", int'(want.write_ignored),
                        int'(out_item.write_ignored));
      end
    end
  end

  // reset pointer, fixed registers, reserved gaps, wrap and the unused mode
  task automatic test_register_map();
    send_word(srpg_pkg::MODE_READ, 8'h00);
    send_word(srpg_pkg::MODE_POINTER, 8'h0f);
    repeat (3) send_word(srpg_pkg::MODE_READ, 8'h00);
    send_word(srpg_pkg::MODE_POINTER, 8'h1f);
    repeat (4) send_word(srpg_pkg::MODE_READ, 8'hff);
    send_word(srpg_pkg::MODE_POINTER, 8'h01);
    send_word(srpg_pkg::MODE_WRITE, 8'hff);
    send_word(srpg_pkg::MODE_WRITE, 8'h00);
    send_word(srpg_pkg::MODE_POINTER, 8'h00);
    send_word(srpg_pkg::MODE_WRITE, 8'haa);    // input register is read-only
    send_word(srpg_pkg::MODE_READ, 8'h00);
    send_word(srpg_pkg::MODE_POINTER, 8'hff);
    send_word(srpg_pkg::MODE_WRITE, 8'h55);    // reserved, pointer wraps to zero
    send_word(srpg_pkg::MODE_READ, 8'h00);
    send_word(srpg_pkg::MODE_UNUSED, 8'hff);
    send_word(srpg_pkg::MODE_READ, 8'h00);
  endtask

  task automatic test_straps();
    srpg_pkg::byte_t p1 [4];
    srpg_pkg::byte_t p2 [4];
    p1 = '{8'hff, 8'h00, 8'ha5, srpg_pkg::byte_t'($urandom_range(0, 255))};
    p2 = '{8'h00, 8'hff, 8'h5a, srpg_pkg::byte_t'($urandom_range(0, 255))};
    for (int s = 0; s < 4; s++) begin
      write_strap(srpg_pkg::CFG_P1_STRAP, p1[s]);
      write_strap(srpg_pkg::CFG_P2_STRAP, p2[s]);
      send_word(srpg_pkg::MODE_POINTER, srpg_pkg::REG_P1_INPUT);
      send_word(srpg_pkg::MODE_READ, 8'h00);
      send_word(srpg_pkg::MODE_POINTER, srpg_pkg::REG_P1_LATCH);
      send_word(srpg_pkg::MODE_READ, 8'h00);
      send_word(srpg_pkg::MODE_POINTER, srpg_pkg::REG_P2_INPUT);
      send_word(srpg_pkg::MODE_READ, 8'h00);
      send_word(srpg_pkg::MODE_POINTER, srpg_pkg::REG_P2_LATCH);
      send_word(srpg_pkg::MODE_WRITE, 8'h3c);
      send_word(srpg_pkg::MODE_POINTER, srpg_pkg::REG_P2_LATCH);
      send_word(srpg_pkg::MODE_READ, 8'h00);
    end
  endtask

  function automatic srpg_pkg::byte_t pick_pointer();
    int r;
    r = $urandom_range(0, 9);
    if (r < 7) return srpg_pkg::byte_t'($urandom_range(0, 8'h23));
    if (r < 8) return srpg_pkg::byte_t'($urandom_range(8'hf8, 8'hff));
    return srpg_pkg::byte_t'($urandom_range(0, 255));
  endfunction

  // mostly well-formed transfers with random content, some stray words
  task automatic test_random_transfers(int target);
    int kind;
    int len;
    int next_change;
    next_change = 200;
    while (n_pointer + n_write + n_read < target) begin
      if (n_pointer + n_write + n_read >= next_change) begin
        next_change += 200;
        gaps_on = ~gaps_on;
        write_strap(srpg_pkg::CFG_P1_STRAP, srpg_pkg::byte_t'($urandom_range(0, 255)));
        write_strap(srpg_pkg::CFG_P2_STRAP, srpg_pkg::byte_t'($urandom_range(0, 255)));
      end
      kind = $urandom_range(0, 9);
      len  = $urandom_range(1, 6);
      if (kind < 6) begin
        send_word(srpg_pkg::MODE_POINTER, pick_pointer());
        repeat (len)
          send_word(srpg_pkg::MODE_WRITE, srpg_pkg::byte_t'($urandom_range(0, 255)));
      end else if (kind < 9) begin
        send_word(srpg_pkg::MODE_POINTER, pick_pointer());
        repeat (len)
          send_word(srpg_pkg::MODE_READ, srpg_pkg::byte_t'($urandom_range(0, 255)));
      end else begin
        send_word(srpg_pkg::mode_t'($urandom_range(0, 3)),
                  srpg_pkg::byte_t'($urandom_range(0, 255)));
      end
      if ($urandom_range(0, 49) == 0) wait_idle();
    end
  endtask

  initial begin
    for (int k = 0; k < srpg_pkg::NUM_SLOTS; k++) shadow_regs[k] = srpg_pkg::SLOT_RESET[k];
    shadow_ptr = '0;
    strap_p1   = '0;
    strap_p2   = '0;
    gaps_on    = 1'b1;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_register_map();
    test_straps();
    test_random_transfers(1400);

    wait_idle();
    if (pending_q.size() != 0) begin
      mismatches += pending_q.size();
      $display("%0d expected words never arrived", pending_q.size());
    end
    $display("Sent %0d pointer, %0d data, %0d read and %0d unused-mode words;",
             n_pointer, n_write, n_read, n_unused);
    $display("%0d writes refused, checked %0d result words, %0d mismatches",
             n_ignored, results_seen, mismatches);
    if (mismatches == 0) begin
      $display("smbus_register_pointer_gpio_regs test passed");
    end else begin
      $display("smbus_register_pointer_gpio_regs test failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("smbus_register_pointer_gpio_regs test failed");
    $finish;
  end

endmodule
